### src/lvwd_pkg.sv
// Shared types and constants for the LZSS variable-width decoder.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps

package lvwd_pkg;

    // History geometry. The depth must be a power of two so that positions wrap freely.
    localparam int HIST_DEPTH      = 4096;
    localparam int HIST_AW         = $clog2(HIST_DEPTH);
    localparam int LEN_W           = $clog2(HIST_DEPTH + 1);

    // Variable field widths taken from the stream header.
    localparam int MAX_FIELD_WIDTH = 16;
    localparam int FW_W            = $clog2(MAX_FIELD_WIDTH + 1);
    localparam int FVAL_W          = MAX_FIELD_WIDTH;
    localparam int DIST_W          = 18;

    // Bit buffer.
    localparam int BUF_W           = 24;
    localparam int BCNT_W          = 5;
    localparam int BUF_ROOM        = BUF_W - 8;

    // A single step never parses more than flag, flag, distance and count.
    localparam int PARSE_STEPS     = 4;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [3:0] {
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_FLAG1,
        PH_FLAG2,
        PH_SHORT,
        PH_LONG,
        PH_LIT,
        PH_COUNT
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_REFUSED,
        ST_LEN,
        ST_HDR
    } status_t;

    // One decoded result waiting for its history byte.
    typedef struct packed {
        logic               out_valid;
        status_t            status;
        logic               copy_busy;
        logic               is_copy;
        logic               zero;
        logic [7:0]         lit;
        logic [HIST_AW-1:0] waddr;
    } item_t;

    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
    } hist_rd_t;

    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
        logic [7:0]         data;
    } hist_wr_t;

endpackage

### src/lvwd_hist.sv
// History memory of the LZSS decoder: one write port and one registered read port.
// Depends on lvwd_pkg.
`timescale 1ns / 1ps

module lvwd_hist
    import lvwd_pkg::*;
(
    input  logic     aclk,
    input  hist_rd_t rd,
    input  hist_wr_t wr,
    output logic [7:0] rd_data
);

    logic [7:0] mem [HIST_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // A read that meets a write to the same entry in the same cycle sees the new byte.
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            if (wr.en && (wr.addr == rd.addr)) begin
                rd_data_reg <= wr.data;
            end else begin
                rd_data_reg <= mem[rd.addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/lvwd_ctrl.sv
// Header capture, bit buffer, token parser and copy bookkeeping of the LZSS decoder.
// Depends on lvwd_pkg; issues reads to lvwd_hist.
`timescale 1ns / 1ps

module lvwd_ctrl
    import lvwd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic       op,
    input  logic [7:0] in_byte,
    input  logic       p_adv,
    output logic       p_valid,
    output item_t      item,
    output hist_rd_t   rd
);

    phase_t              phase_reg, phase_next;
    logic [FW_W-1:0]     cw_reg, cw_next;
    logic [FW_W-1:0]     sw_reg, sw_next;
    logic [FW_W-1:0]     lw_reg, lw_next;
    logic [BUF_W-1:0]    buf_reg, buf_next;
    logic [BCNT_W-1:0]   cnt_reg, cnt_next;
    logic [HIST_AW-1:0]  dist_reg, dist_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [HIST_AW-1:0]  rpos_reg, rpos_next;
    logic [HIST_AW-1:0]  wpos_reg, wpos_next;
    logic                wrapped_reg, wrapped_next;
    status_t             err_reg, err_next;
    logic                p_valid_reg, p_valid_next;
    item_t               item_reg, item_next;

    logic                refused;
    logic                lit_fire;
    logic                copy_fire;
    logic                run_parse;
    logic                stop;
    logic [7:0]          lit_val;
    phase_t              pph;
    logic [BUF_W-1:0]    pb;
    logic [BUF_W-1:0]    shifted;
    logic [BCNT_W-1:0]   pc;
    logic [FW_W-1:0]     n;
    logic [FVAL_W-1:0]   val;
    logic [FVAL_W:0]     len;

    // Next state: one step of the decoder, parsing at most one token from the buffered bits.
    always_comb begin
        phase_next   = phase_reg;
        cw_next      = cw_reg;
        sw_next      = sw_reg;
        lw_next      = lw_reg;
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        dist_next    = dist_reg;
        rem_next     = rem_reg;
        rpos_next    = rpos_reg;
        wpos_next    = wpos_reg;
        wrapped_next = wrapped_reg;
        err_next     = err_reg;
        refused      = 1'b0;
        lit_fire     = 1'b0;
        copy_fire    = 1'b0;
        run_parse    = 1'b0;
        stop         = 1'b0;
        lit_val      = 8'd0;
        pph          = phase_reg;
        pb           = buf_reg;
        pc           = cnt_reg;
        n            = '0;
        val          = '0;
        shifted      = '0;
        len          = '0;

        if (err_reg == ST_OK) begin
            if (op == OP_PUSH) begin
                if ((rem_reg != '0) || (cnt_reg > BCNT_W'(BUF_ROOM))) begin
                    refused = 1'b1;
                end else if ((phase_reg == PH_HDR0) || (phase_reg == PH_HDR1) ||
                             (phase_reg == PH_HDR2)) begin
                    if (in_byte > 8'(MAX_FIELD_WIDTH)) begin
                        err_next = ST_HDR;
                    end else if (phase_reg == PH_HDR0) begin
                        cw_next    = in_byte[FW_W-1:0];
                        phase_next = PH_HDR1;
                    end else if (phase_reg == PH_HDR1) begin
                        sw_next    = in_byte[FW_W-1:0];
                        phase_next = PH_HDR2;
                    end else begin
                        lw_next    = in_byte[FW_W-1:0];
                        phase_next = PH_FLAG1;
                    end
                end else begin
                    pb        = {buf_reg[BUF_W-9:0], in_byte};
                    pc        = cnt_reg + BCNT_W'(8);
                    run_parse = 1'b1;
                end
            end else if (rem_reg != '0) begin
                copy_fire = 1'b1;
                rpos_next = rpos_reg + HIST_AW'(1);
                rem_next  = rem_reg - LEN_W'(1);
            end else if (phase_reg > PH_HDR2) begin
                run_parse = 1'b1;
            end
        end

        if (run_parse) begin
            for (int i = 0; i < PARSE_STEPS; i++) begin
                if (!stop) begin
                    unique case (pph)
                        PH_FLAG1: n = FW_W'(1);
                        PH_FLAG2: n = FW_W'(1);
                        PH_SHORT: n = sw_reg;
                        PH_LONG:  n = lw_reg;
                        PH_LIT:   n = FW_W'(8);
                        PH_COUNT: n = cw_reg;
                        default:  n = '0;
                    endcase
                    if (BCNT_W'(n) > pc) begin
                        stop = 1'b1;
                    end else begin
                        shifted = pb >> (pc - BCNT_W'(n));
                        val     = shifted[FVAL_W-1:0] &
                                  FVAL_W'(((FVAL_W+1)'(1) << n) - (FVAL_W+1)'(1));
                        pc      = pc - BCNT_W'(n);
                        pb      = pb & BUF_W'(((BUF_W+1)'(1) << pc) - (BUF_W+1)'(1));
                        unique case (pph)
                            PH_FLAG1: pph = val[0] ? PH_FLAG2 : PH_SHORT;
                            PH_FLAG2: pph = val[0] ? PH_LIT : PH_LONG;
                            PH_SHORT: begin
                                dist_next = val[HIST_AW-1:0] + HIST_AW'(2);
                                pph       = PH_COUNT;
                            end
                            PH_LONG: begin
                                dist_next = val[HIST_AW-1:0] + HIST_AW'(2) +
                                            HIST_AW'(DIST_W'(1) << sw_reg);
                                pph       = PH_COUNT;
                            end
                            PH_LIT: begin
                                lit_val  = val[7:0];
                                lit_fire = 1'b1;
                                pph      = PH_FLAG1;
                                stop     = 1'b1;
                            end
                            PH_COUNT: begin
                                len  = (FVAL_W+1)'(val) + (FVAL_W+1)'(2);
                                stop = 1'b1;
                                if (len > (FVAL_W+1)'(HIST_DEPTH)) begin
                                    err_next = ST_LEN;
                                end else begin
                                    rem_next  = LEN_W'(len);
                                    rpos_next = wpos_reg - dist_next;
                                    pph       = PH_FLAG1;
                                end
                            end
                            default: stop = 1'b1;
                        endcase
                    end
                end
            end
            buf_next   = pb;
            cnt_next   = pc;
            phase_next = pph;
        end

        if (lit_fire || copy_fire) begin
            wpos_next = wpos_reg + HIST_AW'(1);
            if (wpos_reg == '1) begin
                wrapped_next = 1'b1;
            end
        end
    end

    // Outputs: the result of this step and the history read that it needs.
    always_comb begin
        item_next.out_valid = (lit_fire || copy_fire) && (err_next == ST_OK);
        if (err_next != ST_OK) begin
            item_next.status = err_next;
        end else if (refused) begin
            item_next.status = ST_REFUSED;
        end else begin
            item_next.status = ST_OK;
        end
        item_next.copy_busy = (err_next == ST_OK) && (rem_next != '0);
        item_next.is_copy   = copy_fire;
        // An entry that was never written reads as the cleared value.
        item_next.zero      = copy_fire && !wrapped_reg && (rpos_reg >= wpos_reg);
        item_next.lit       = lit_val;
        item_next.waddr     = wpos_reg;

        rd.en   = accept && copy_fire;
        rd.addr = rpos_reg;

        if (accept) begin
            p_valid_next = 1'b1;
        end else if (p_adv) begin
            p_valid_next = 1'b0;
        end else begin
            p_valid_next = p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR0;
            cw_reg      <= '0;
            sw_reg      <= '0;
            lw_reg      <= '0;
            buf_reg     <= '0;
            cnt_reg     <= '0;
            dist_reg    <= '0;
            rem_reg     <= '0;
            rpos_reg    <= '0;
            wpos_reg    <= '0;
            wrapped_reg <= 1'b0;
            err_reg     <= ST_OK;
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            if (accept) begin
                phase_reg   <= phase_next;
                cw_reg      <= cw_next;
                sw_reg      <= sw_next;
                lw_reg      <= lw_next;
                buf_reg     <= buf_next;
                cnt_reg     <= cnt_next;
                dist_reg    <= dist_next;
                rem_reg     <= rem_next;
                rpos_reg    <= rpos_next;
                wpos_reg    <= wpos_next;
                wrapped_reg <= wrapped_next;
                err_reg     <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign p_valid = p_valid_reg;
    assign item    = item_reg;

    // Once an error is recorded it never changes.
    a_err_sticky : assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ST_OK) |=> (err_reg == $past(err_reg)))
        else $error("lvwd_ctrl: error code changed after being set");

    // A pending copy never exceeds the history size.
    a_rem_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= LEN_W'(HIST_DEPTH))
        else $error("lvwd_ctrl: copy length beyond history size");

endmodule

### src/lzss_variable_width_decoder.sv
// Top level of the LZSS variable-width decoder: parser stage, history memory, output register.
// Depends on lvwd_pkg, lvwd_ctrl and lvwd_hist.
// An accepted transaction goes through the item register and then the output register to m_*.
// Throughput: one input transaction per cycle while m_* drains, set by the single history ports.
// Reset (aresetn low, synchronous) clears all control state; the history memory is not swept,
// since a fill pointer makes any entry not yet written read as zero, so no clearing pass is run.
`timescale 1ns / 1ps

module lzss_variable_width_decoder
    import lvwd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_out_valid,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_status,
    output logic       m_copy_busy
);

    // The decoder is a short pipeline. In the first stage lvwd_ctrl takes a transaction,
    // runs the header and token parser and updates the buffered bits and copy pointers,
    // and a copy tick issues its history read. In the second stage the history byte
    // arrives, the result byte is selected and written back into the history, and the
    // result moves into the output register. A read that meets the write of the previous
    // result to the same entry is forwarded inside the memory.

    logic       accept;
    logic       p_valid;
    logic       p_adv;
    item_t      item;
    hist_rd_t   rd;
    hist_wr_t   wr;
    logic [7:0] rd_data;
    logic [7:0] p_byte;

    logic       m_valid_reg, m_valid_next;
    logic       m_out_valid_reg;
    logic [7:0] m_out_byte_reg;
    status_t    m_status_reg;
    logic       m_copy_busy_reg;

    // The second stage moves on whenever the output register is empty or being emptied,
    // so a new transaction can be taken while a finished result still waits downstream.
    assign p_adv   = p_valid && (!m_valid_reg || m_ready);
    assign s_ready = !p_valid || p_adv;
    assign accept  = s_valid && s_ready;

    lvwd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .op      (s_op),
        .in_byte (s_in_byte),
        .p_adv   (p_adv),
        .p_valid (p_valid),
        .item    (item),
        .rd      (rd)
    );

    lvwd_hist u_hist (
        .aclk    (aclk),
        .rd      (rd),
        .wr      (wr),
        .rd_data (rd_data)
    );

    // Result byte: a literal comes straight from the parser, a copy byte from the history.
    always_comb begin
        if (!item.out_valid) begin
            p_byte = 8'd0;
        end else if (item.is_copy) begin
            p_byte = item.zero ? 8'd0 : rd_data;
        end else begin
            p_byte = item.lit;
        end
    end

    // Every emitted byte, literal or copied, is appended to the history.
    always_comb begin
        wr.en   = p_adv && item.out_valid;
        wr.addr = item.waddr;
        wr.data = p_byte;
    end

    always_comb begin
        if (p_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_adv) begin
            m_out_valid_reg <= item.out_valid;
            m_out_byte_reg  <= p_byte;
            m_status_reg    <= item.status;
            m_copy_busy_reg <= item.copy_busy;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_valid = m_out_valid_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_status    = m_status_reg;
    assign m_copy_busy = m_copy_busy_reg;

    // No new transaction is taken while both stages are full and the output is stalled.
    a_no_overrun : assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid && m_valid && !m_ready) |-> !s_ready)
        else $error("lzss decoder: input taken while the pipeline is blocked");

    // An emitted byte always comes with an ok status.
    a_byte_ok : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_valid) |-> (m_status == ST_OK))
        else $error("lzss decoder: byte emitted with a non-ok status");

    // An error result carries no byte and no pending copy.
    a_err_quiet : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_status == ST_LEN) || (m_status == ST_HDR))) |->
        (!m_out_valid && !m_copy_busy && (m_out_byte == 8'd0)))
        else $error("lzss decoder: error result carries data");

endmodule

### dv/lvwd_checker.sv
// Transaction checker for the LZSS variable-width decoder: predicts every result from the
// accepted input transactions and compares it with what the decoder returns.
// Depends on lvwd_pkg for widths, the phase and status enums and the operation codes.
`timescale 1ns / 1ps

module lvwd_checker
    import lvwd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_op,
    input  logic [7:0]        s_in_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_out_valid,
    input  logic [7:0]        m_out_byte,
    input  logic [1:0]        m_status,
    input  logic              m_copy_busy,
    output int                fail_count,
    output int                pending,
    output logic              copy_pending,
    output logic [BCNT_W-1:0] bits_held,
    output logic              stream_fault
);

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
        status_t    st;
        logic       busy;
    } dec_out_t;

    // Shadow of the decoder state.
    phase_t             ph;
    logic [FW_W-1:0]    cnt_w;
    logic [FW_W-1:0]    sh_w;
    logic [FW_W-1:0]    lg_w;
    logic [BUF_W-1:0]   bitbuf;
    logic [BCNT_W-1:0]  nbits;
    logic [DIST_W-1:0]  back_dist;
    logic [LEN_W-1:0]   copy_left;
    logic [HIST_AW-1:0] rd_ptr;
    logic [HIST_AW-1:0] wr_ptr;
    logic [7:0]         hist [HIST_DEPTH];
    status_t            fault;

    dec_out_t predicted_outs[$];

    assign copy_pending = (copy_left != '0);
    assign bits_held    = nbits;
    assign stream_fault = (fault != ST_OK);

    task automatic clear_model();
        ph        = PH_HDR0;
        cnt_w     = '0;
        sh_w      = '0;
        lg_w      = '0;
        bitbuf    = '0;
        nbits     = '0;
        back_dist = '0;
        copy_left = '0;
        rd_ptr    = '0;
        wr_ptr    = '0;
        fault     = ST_OK;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            hist[i] = 8'h00;
        end
    endtask

    // Takes n bits from the top of the buffered bits, most significant first.
    function automatic logic grab(input int n, output logic [FVAL_W-1:0] v);
        logic [BUF_W-1:0] t;
        v = '0;
        if (n > int'(nbits)) begin
            return 1'b0;
        end
        t      = (bitbuf >> (int'(nbits) - n)) & ((BUF_W'(1) << n) - BUF_W'(1));
        v      = t[FVAL_W-1:0];
        nbits  = nbits - n[BCNT_W-1:0];
        bitbuf = bitbuf & ((BUF_W'(1) << nbits) - BUF_W'(1));
        return 1'b1;
    endfunction

    function automatic void put_hist(input logic [7:0] b);
        hist[wr_ptr] = b;
        wr_ptr       = wr_ptr + 1'b1;
    endfunction

    // Parses until a literal comes out, a copy is set up, or the bits run out.
    function automatic logic run_parser(output logic [7:0] lit);
        logic [FVAL_W-1:0] v;
        logic [31:0]       w;
        logic              done;
        logic              emitted;
        lit     = 8'h00;
        done    = 1'b0;
        emitted = 1'b0;
        while (!done) begin
            unique case (ph)
                PH_FLAG1: begin
                    if (!grab(1, v)) done = 1'b1;
                    else ph = v[0] ? PH_FLAG2 : PH_SHORT;
                end
                PH_FLAG2: begin
                    if (!grab(1, v)) done = 1'b1;
                    else ph = v[0] ? PH_LIT : PH_LONG;
                end
                PH_SHORT: begin
                    if (!grab(int'(sh_w), v)) begin
                        done = 1'b1;
                    end else begin
                        w         = 32'd2 + 32'(v);
                        back_dist = w[DIST_W-1:0];
                        ph        = PH_COUNT;
                    end
                end
                PH_LONG: begin
                    if (!grab(int'(lg_w), v)) begin
                        done = 1'b1;
                    end else begin
                        w         = 32'd2 + (32'd1 << sh_w) + 32'(v);
                        back_dist = w[DIST_W-1:0];
                        ph        = PH_COUNT;
                    end
                end
                PH_LIT: begin
                    done = 1'b1;
                    if (grab(8, v)) begin
                        lit     = v[7:0];
                        put_hist(lit);
                        ph      = PH_FLAG1;
                        emitted = 1'b1;
                    end
                end
                PH_COUNT: begin
                    done = 1'b1;
                    if (grab(int'(cnt_w), v)) begin
                        w = 32'd2 + 32'(v);
                        if (w > HIST_DEPTH) begin
                            fault = ST_LEN;
                        end else begin
                            copy_left = w[LEN_W-1:0];
                            // The depth is a power of two, so the low bits give the wrap.
                            rd_ptr    = wr_ptr - back_dist[HIST_AW-1:0];
                            ph        = PH_FLAG1;
                        end
                    end
                end
                default: done = 1'b1;
            endcase
        end
        return emitted;
    endfunction

    function automatic dec_out_t decode_step(input logic op, input logic [7:0] b);
        dec_out_t   r;
        logic [7:0] ob;
        logic       got;
        ob  = 8'h00;
        got = 1'b0;
        r   = '0;
        r.st = ST_OK;
        if (fault == ST_OK) begin
            if (op == OP_PUSH) begin
                if (copy_left != '0 || nbits > BUF_ROOM) begin
                    r.st = ST_REFUSED;
                end else if (ph <= PH_HDR2) begin
                    if (b > MAX_FIELD_WIDTH) begin
                        fault = ST_HDR;
                    end else if (ph == PH_HDR0) begin
                        cnt_w = b[FW_W-1:0];
                        ph    = PH_HDR1;
                    end else if (ph == PH_HDR1) begin
                        sh_w = b[FW_W-1:0];
                        ph   = PH_HDR2;
                    end else begin
                        lg_w = b[FW_W-1:0];
                        ph   = PH_FLAG1;
                    end
                end else begin
                    bitbuf = {bitbuf[BUF_W-9:0], b};
                    nbits  = nbits + BCNT_W'(8);
                    got    = run_parser(ob);
                end
            end else if (copy_left != '0) begin
                ob        = hist[rd_ptr];
                put_hist(ob);
                rd_ptr    = rd_ptr + 1'b1;
                copy_left = copy_left - 1'b1;
                got       = 1'b1;
            end else if (ph > PH_HDR2) begin
                got = run_parser(ob);
            end
        end
        if (fault != ST_OK) begin
            got  = 1'b0;
            r.st = fault;
        end
        r.vld  = got;
        r.data = got ? ob : 8'h00;
        r.busy = (fault == ST_OK) && (copy_left != '0);
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        $error("%s: expected %0h, got %0h", field, want_v, got_v);
        fail_count++;
    endtask

    // Results are taken before inputs, so a result can never be matched with an
    // input transaction accepted at the same edge.
    always @(posedge aclk) begin : track
        dec_out_t want;
        if (!aresetn) begin
            clear_model();
            predicted_outs.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_outs.size() == 0) begin
                    $error("result transaction arrived with no prediction waiting");
                    fail_count++;
                end else begin
                    want = predicted_outs.pop_front();
                    if (m_out_valid !== want.vld)
                        note_mismatch("out_valid", 8'(want.vld), 8'(m_out_valid));
                    if (m_out_byte !== want.data)
                        note_mismatch("out_byte", want.data, m_out_byte);
                    if (m_status !== want.st)
                        note_mismatch("status", 8'(want.st), 8'(m_status));
                    if (m_copy_busy !== want.busy)
                        note_mismatch("copy_busy", 8'(want.busy), 8'(m_copy_busy));
                end
            end
            if (s_valid && s_ready) begin
                predicted_outs.push_back(decode_step(s_op, s_in_byte));
            end
        end
        pending = predicted_outs.size();
    end

endmodule

### dv/tb_top.sv
// Top of the decoder testbench: clock, reset, an encoder that builds LZSS token streams,
// stimulus with idle and stall phases, and the final verdict.
// Depends on lvwd_pkg, lvwd_checker and lzss_variable_width_decoder.
`timescale 1ns / 1ps

module tb_top;
    import lvwd_pkg::*;

    // Number of input transactions in the random part.
    localparam int N_RANDOM = 1280;
    localparam int N_SEGS   = 8;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic              s_op      = OP_PUSH;
    logic [7:0]        s_in_byte = 8'h00;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic              m_out_valid;
    logic [7:0]        m_out_byte;
    logic [1:0]        m_status;
    logic              m_copy_busy;

    int                fail_count;
    int                pending;
    logic              copy_pending;
    logic [BCNT_W-1:0] bits_held;
    logic              stream_fault;

    // Stream widths chosen for this run; the header carries them to the decoder.
    int cnt_w;
    int sh_w;
    int lg_w;

    // Percentages that shape the traffic: sender gaps, receiver stalls, and how often a
    // push is thrown at the decoder while it is copying (and therefore refused).
    int idle_pct  = 0;
    int stall_pct = 0;
    int noise_pct = 10;

    int items_sent = 0;

    // Encoded bytes waiting to go out, and the bits of a byte still being assembled.
    logic [7:0] stream_bytes[$];
    logic [7:0] part   = 8'h00;
    int         part_n = 0;

    lzss_variable_width_decoder u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_valid (m_out_valid),
        .m_out_byte  (m_out_byte),
        .m_status    (m_status),
        .m_copy_busy (m_copy_busy)
    );

    lvwd_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_in_byte    (s_in_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_valid  (m_out_valid),
        .m_out_byte   (m_out_byte),
        .m_status     (m_status),
        .m_copy_busy  (m_copy_busy),
        .fail_count   (fail_count),
        .pending      (pending),
        .copy_pending (copy_pending),
        .bits_held    (bits_held),
        .stream_fault (stream_fault)
    );

    always #2 aclk = ~aclk;

    // The receiver stalls at random; the rate follows the current traffic phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Appends n bits of val to the stream, most significant first, as the decoder reads them.
    task automatic put_bits(input logic [15:0] val, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            part = {part[6:0], val[i]};
            part_n++;
            if (part_n == 8) begin
                stream_bytes.push_back(part);
                part_n = 0;
            end
        end
    endtask

    task automatic put_literal(input logic [7:0] b);
        put_bits(16'b11, 2);
        put_bits({8'h00, b}, 8);
    endtask

    // A short reference reaches back 2 plus the field; its length is 2 plus the count.
    task automatic put_short_ref(input logic [15:0] field, input logic [15:0] count);
        put_bits(16'b0, 1);
        put_bits(field, sh_w);
        put_bits(count, cnt_w);
    endtask

    // A long reference starts beyond the reach of the short form.
    task automatic put_long_ref(input logic [15:0] field, input logic [15:0] count);
        put_bits(16'b10, 2);
        put_bits(field, lg_w);
        put_bits(count, cnt_w);
    endtask

    function automatic logic [15:0] all_ones(input int w);
        return 16'((32'd1 << w) - 32'd1);
    endfunction

    function automatic logic [15:0] rand_field(input int w);
        return 16'($urandom) & all_ones(w);
    endfunction

    // Widths lean towards their extremes so that the boundaries turn up often.
    function automatic int pick_width(input int lo, input int hi);
        unique case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // Copy lengths are mostly short, so the run is not swamped by copy ticks.
    function automatic logic [15:0] rand_count();
        int r;
        r = $urandom_range(99);
        if (r < 90)
            return 16'($urandom_range(6));
        else if (r < 99)
            return 16'($urandom_range(60));
        else
            return 16'($urandom_range(600, 61));
    endfunction

    task automatic gen_token();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            put_literal(8'($urandom));
        else if (r < 70)
            put_short_ref(rand_field(sh_w), rand_count());
        else
            put_long_ref(rand_field(lg_w), rand_count());
    endtask

    // Picks the next input transaction from what the decoder is expected to be doing. A
    // pending copy or a full bit buffer gets ticks, with an occasional stray push that the
    // decoder must refuse; otherwise the next stream byte goes out, with the odd tick mixed
    // in. Stray pushes are only sent where they will be refused, so the stream stays intact.
    task automatic choose(output logic op, output logic [7:0] b);
        b = 8'($urandom);
        if (stream_fault) begin
            op = $urandom_range(1) ? OP_TICK : OP_PUSH;
            if (op == OP_PUSH && stream_bytes.size() != 0)
                b = stream_bytes.pop_front();
        end else if (copy_pending) begin
            op = ($urandom_range(99) < noise_pct) ? OP_PUSH : OP_TICK;
        end else if (bits_held > BUF_ROOM) begin
            op = ($urandom_range(99) < 30) ? OP_PUSH : OP_TICK;
        end else if (stream_bytes.size() == 0 || $urandom_range(99) < 8) begin
            op = OP_TICK;
        end else begin
            op = OP_PUSH;
            b  = stream_bytes.pop_front();
        end
    endtask

    // Presents one input transaction and holds it until it is accepted. It is entered and
    // left at a falling edge, so valid changes only there and only once per step. With
    // steer set, the transaction is chosen at the edge where it goes out, when the
    // checker's view already covers every transaction accepted before it.
    task automatic offer(input bit steer, input logic op_in, input logic [7:0] byte_in);
        logic       op;
        logic [7:0] b;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        op = op_in;
        b  = byte_in;
        if (steer)
            choose(op, b);
        s_valid   <= 1'b1;
        s_op      <= op;
        s_in_byte <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Ticks before the header have nothing to do and must come back empty.
        offer(1'b0, OP_TICK, 8'h00);
        offer(1'b0, OP_TICK, 8'hFF);

        // The count field must be able to express a length beyond the history, so its
        // width starts at twelve bits; the distance widths take any legal value.
        cnt_w = pick_width(12, MAX_FIELD_WIDTH);
        sh_w  = pick_width(0, MAX_FIELD_WIDTH);
        lg_w  = pick_width(0, MAX_FIELD_WIDTH);
        offer(1'b0, OP_PUSH, 8'(cnt_w));
        offer(1'b0, OP_PUSH, 8'(sh_w));
        offer(1'b0, OP_PUSH, 8'(lg_w));

        // Directed tokens: extreme literals, both reference forms with the smallest and
        // largest distance fields, and a good share of pushes refused during copies.
        noise_pct = 50;
        put_literal(8'h00);
        put_literal(8'hFF);
        put_short_ref(16'h0000, 16'd0);
        put_short_ref(all_ones(sh_w), 16'd1);
        put_long_ref(16'h0000, 16'd0);
        put_long_ref(all_ones(lg_w), 16'd2);
        put_literal(8'h5A);
        put_short_ref(16'h0001, 16'd3);
        while (stream_bytes.size() != 0 || copy_pending)
            offer(1'b1, OP_TICK, 8'h00);

        // The sender holds off until every outstanding result has been returned.
        s_valid <= 1'b0;
        wait (pending == 0);
        @(negedge aclk);

        // Random part in segments that rotate through the traffic phases: free flowing,
        // a mostly idle sender, a mostly stalled receiver, and light gaps on both sides.
        noise_pct = 10;
        for (int seg = 0; seg < N_SEGS; seg++) begin
            unique case (seg % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 71; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 6;  stall_pct = 6;  end
            endcase
            while (items_sent < (seg + 1) * N_RANDOM / N_SEGS) begin
                if (stream_bytes.size() == 0)
                    gen_token();
                offer(1'b1, OP_TICK, 8'h00);
            end
        end

        // Finish with a length one above the history depth, the shortest that is too long:
        // the decoder latches the error, and everything after it must report that error.
        idle_pct  = 6;
        stall_pct = 6;
        put_long_ref(rand_field(lg_w), 16'(HIST_DEPTH - 1));
        while (part_n != 0)
            put_bits(16'h0000, 1);
        while (stream_bytes.size() != 0 || !stream_fault)
            offer(1'b1, OP_TICK, 8'h00);
        repeat (12)
            offer(1'b1, OP_TICK, 8'h00);

        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
